// ----- hdl/rmt_pkg.sv -----
package rmt_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STAT_W   = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_REM_RD,
        S_REM_WR,
        S_MED_RD,
        S_MED_DATA
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  median;
        logic               median_valid;
        logic [COUNT_W-1:0] count;
        logic [STAT_W-1:0]  status;
    } result_t;

endpackage

// ----- hdl/rmt_store.sv -----
module rmt_store (
    input  logic                          clk,
    input  rmt_pkg::mem_req_t             req,
    output logic [rmt_pkg::DATA_W-1:0]    rd_data
);
    import rmt_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/rmt_seq.sv -----
module rmt_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  logic [rmt_pkg::DATA_W-1:0]    in_value,
    output rmt_pkg::mem_req_t             mem_req,
    input  logic [rmt_pkg::DATA_W-1:0]    rd_data,
    output logic                          res_load,
    output rmt_pkg::result_t              result
);
    import rmt_pkg::*;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic signed [DATA_W-1:0]  val_reg, val_next;
    logic [DATA_W-1:0]         median_reg, median_next;
    logic [STAT_W-1:0]         status_reg, status_next;

    logic                      accept;
    logic                      data_gt;
    logic [CNT_W-1:0]          idx_inc;
    logic [CNT_W-1:0]          mid_idx;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign data_gt  = $signed(rd_data) > val_reg;
    assign idx_inc  = idx_reg + 1'b1;
    assign mid_idx  = (count_reg - 1'b1) >> 1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_INSERT)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY) || count_reg == '0)
                            state_next = S_MED_RD;
                        else
                            state_next = S_INS_RD;
                    end
                    else
                    begin
                        if (count_reg == '0)
                            state_next = S_MED_RD;
                        else
                            state_next = S_REM_RD;
                    end
                end
            end
            S_INS_RD:   state_next = S_INS_CMP;
            S_INS_CMP:
            begin
                if (!data_gt)
                    state_next = S_MED_RD;
                else if (idx_reg == '0)
                    state_next = S_INS_PUT;
                else
                    state_next = S_INS_RD;
            end
            S_INS_PUT:  state_next = S_MED_RD;
            S_REM_RD:
            begin
                if (idx_reg < count_reg)
                    state_next = S_REM_WR;
                else
                    state_next = S_MED_RD;
            end
            S_REM_WR:   state_next = S_REM_RD;
            S_MED_RD:
            begin
                if (count_reg == '0)
                    state_next = S_IDLE;
                else
                    state_next = S_MED_DATA;
            end
            S_MED_DATA: state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        mem_req     = '0;
        count_next  = count_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        median_next = median_reg;
        status_next = status_reg;
        res_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    val_next    = in_value;
                    if (in_cmd == CMD_INSERT)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            idx_next   = count_reg - 1'b1;
                            if (count_reg == '0)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = '0;
                                mem_req.wdata = in_value;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            idx_next   = mid_idx;
                        end
                    end
                end
            end
            S_INS_RD:
            begin
                mem_req.raddr = idx_reg[ADDR_W-1:0];
            end
            S_INS_CMP:
            begin
                // shift larger entry up, or drop the value in above it
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_inc[ADDR_W-1:0];
                mem_req.wdata = data_gt ? rd_data : val_reg;
                if (data_gt && idx_reg != '0)
                    idx_next = idx_reg - 1'b1;
            end
            S_INS_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = val_reg;
            end
            S_REM_RD:
            begin
                mem_req.raddr = idx_inc[ADDR_W-1:0];
            end
            S_REM_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg[ADDR_W-1:0];
                mem_req.wdata = rd_data;
                idx_next      = idx_inc;
            end
            S_MED_RD:
            begin
                mem_req.raddr = mid_idx[ADDR_W-1:0];
                if (count_reg == '0)
                begin
                    median_next = '0;
                    res_load    = 1'b1;
                end
            end
            S_MED_DATA:
            begin
                median_next = rd_data;
                res_load    = 1'b1;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    assign result.median       = median_next;
    assign result.median_valid = (count_reg != '0);
    assign result.count        = COUNT_W'(count_reg);
    assign result.status       = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        median_reg <= median_next;
        status_reg <= status_next;
    end

endmodule

// ----- hdl/running_median_tracker_unit.sv -----
// An insert shifts each larger entry up one slot, then drops the value in and reads the
//   median; into an empty or a full store it goes straight to the median read. A removal
//   takes out the median entry by shifting the entries above it down, then reads the median.
// One request at a time; the sorted store is scanned through its one read and one write port.
// A result waits in an output register; the next request waits until it is taken.
// Reset (rst_n, async, active low) empties the store; store contents are not cleared.
module running_median_tracker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] median, [38:32] count, [40:39] status
    output logic        m_tuser    // [0] median_valid
);
    import rmt_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;
    logic              res_load;
    logic              seq_ready;
    logic              out_free;
    result_t           result;
    result_t           out_reg;
    logic              m_tvalid_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    // a finished item must find the output slot free before the next request
    assign s_tready = seq_ready && out_free;

    rmt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid && out_free),
        .in_ready (seq_ready),
        .in_cmd   (s_tuser),
        .in_value (s_tdata),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .res_load (res_load),
        .result   (result)
    );

    rmt_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.median_valid;
    assign m_tdata  = {7'd0, out_reg.status, out_reg.count, out_reg.median};

endmodule

// ----- tb/sv/running_median_tracker_checker.sv -----
`timescale 1ns / 1ps
module running_median_tracker_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [31:0] median, [38:32] count, [40:39] status
    input  logic        m_tuser,   // [0] median_valid
    output int          errors,
    output int          outstanding
);
    import rmt_pkg::*;

    logic signed [DATA_W-1:0] sorted_store [CAPACITY];
    int                       held;
    result_t                  expected_medians [$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
        held        = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
        errors++;
    endtask

    // updates the tracked multiset and returns the result the request should produce
    function automatic result_t apply_request(input logic cmd,
                                              input logic signed [DATA_W-1:0] v);
        result_t r;
        int      pos;
        r.status = STAT_OK;
        if (cmd == CMD_INSERT)
        begin
            if (held >= CAPACITY)
                r.status = STAT_FULL;
            else
            begin
                pos = 0;
                while (pos < held && sorted_store[pos] <= v)
                    pos++;
                for (int i = held; i > pos; i--)
                    sorted_store[i] = sorted_store[i-1];
                sorted_store[pos] = v;
                held++;
            end
        end
        else
        begin
            if (held == 0)
                r.status = STAT_EMPTY;
            else
            begin
                for (int i = (held - 1) / 2; i + 1 < held; i++)
                    sorted_store[i] = sorted_store[i+1];
                held--;
            end
        end
        r.median_valid = (held > 0);
        r.median       = (held > 0) ? sorted_store[(held - 1) / 2] : '0;
        r.count        = COUNT_W'(held);
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.median       = m_tdata[31:0];
                got.count        = m_tdata[38:32];
                got.status       = m_tdata[40:39];
                got.median_valid = m_tuser;
                if (expected_medians.size() == 0)
                    report_mismatch("result with no request pending", '0, got.median);
                else
                begin
                    want = expected_medians.pop_front();
                    if (got.median !== want.median)
                        report_mismatch("median", want.median, got.median);
                    if (got.median_valid !== want.median_valid)
                        report_mismatch("median_valid", 32'(want.median_valid),
                                        32'(got.median_valid));
                    if (got.count !== want.count)
                        report_mismatch("count", 32'(want.count), 32'(got.count));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(got.status));
                end
            end
            // a result never leaves in the cycle its request is taken, so check first
            if (s_tvalid && s_tready)
                expected_medians.insert(expected_medians.size(),
                                        apply_request(s_tuser, s_tdata));
        end
        outstanding = expected_medians.size();
    end

endmodule

// ----- tb/sv/running_median_tracker_unit_tb.sv -----
`timescale 1ns / 1ps
module running_median_tracker_unit_tb;
    import rmt_pkg::*;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] value
    logic        s_tuser  = 1'b0;  // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // [31:0] median, [38:32] count, [40:39] status
    logic        m_tuser;          // [0] median_valid

    int   errors;
    int   outstanding;
    int   tx_idle_pct = 30;
    int   rx_idle_pct = 51;
    logic hold_req    = 1'b0;
    logic hold_armed;
    int   hold_left;

    mix_t mix       = MIX_FILL;
    int   mix_left  = 60;
    int   occupancy = 0;

    running_median_tracker_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    running_median_tracker_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_req && hold_armed)
        begin
            hold_left  <= 300;
            hold_armed <= 1'b0;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_request(input logic cmd, input logic [31:0] val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return $urandom_range(16) - 8;
        if (sel < 55)
        begin
            case ($urandom_range(6))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                3: return 32'hffff_ffff;
                4: return 32'h8000_0001;
                5: return 32'h7fff_fffe;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom();
    endfunction

    // insert/remove mix steered by tracked fill level so full and empty are both reached
    task automatic random_run(input int n);
        logic ins;
        for (int k = 0; k < n; k++)
        begin
            case (mix)
                MIX_FILL:  ins = ($urandom_range(99) < 92);
                MIX_DRAIN: ins = ($urandom_range(99) < 10);
                default:   ins = ($urandom_range(99) < 55);
            endcase
            if (ins && occupancy < CAPACITY)
                occupancy++;
            else if (!ins && occupancy > 0)
                occupancy--;
            send_request(ins ? CMD_INSERT : CMD_REMOVE, pick_value());
            mix_left--;
            if ((mix == MIX_FILL && occupancy == CAPACITY) ||
                (mix == MIX_DRAIN && occupancy == 0))
            begin
                if (mix_left > 3)
                    mix_left = 3;
            end
            if (mix_left <= 0)
            begin
                if (occupancy == CAPACITY)
                    mix = MIX_DRAIN;
                else if (occupancy == 0)
                    mix = MIX_FILL;
                else
                    mix = mix_t'($urandom_range(2));
                mix_left = $urandom_range(70, 20);
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_request(CMD_REMOVE, 32'h1234_5678);
        send_request(CMD_INSERT, 32'h7fff_ffff);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'hffff_ffff);
        send_request(CMD_INSERT, 32'hffff_ffff);
        send_request(CMD_INSERT, 32'h5555_5555);
        send_request(CMD_INSERT, 32'haaaa_aaaa);
        send_request(CMD_REMOVE, 32'hffff_ffff);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_INSERT, 32'h0000_0001);
        send_request(CMD_REMOVE, 32'h0);
        send_request(CMD_REMOVE, 32'h0);
        send_request(CMD_REMOVE, 32'h0);
        send_request(CMD_REMOVE, 32'h0);
        send_request(CMD_REMOVE, 32'h0);
        send_request(CMD_REMOVE, 32'h0);
        send_request(CMD_REMOVE, 32'h0);
        send_request(CMD_INSERT, 32'h7fff_fffe);
        send_request(CMD_REMOVE, 32'h0);
        occupancy = 0;

        random_run(200);
        wait_for_results();

        tx_idle_pct = 51;
        rx_idle_pct = 30;
        hold_req <= 1'b1;
        random_run(200);
        wait_for_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_run(200);
        wait_for_results();

        repeat (150) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("running_median_tracker_unit_tb OK");
        else
            $display("running_median_tracker_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("running_median_tracker_unit_tb NOT OK");
        $finish;
    end

endmodule
